[design/wfpd_pkg.sv]
// Package for the wall-following PD steering block: widths, constants, types.
// Used by wfpd_ctrl, wfpd_dp and wall_following_pd_steering.
`default_nettype none
package wfpd_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] RegTarget = 3'd0;
    localparam logic [CfgIdxW-1:0] RegKp     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegKd     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegLook   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMaxRate = 3'd4;

    localparam logic [15:0] Sin45Q16 = 16'd46341;
    localparam logic [15:0] KinvQ16  = 16'd39797;
    localparam logic [9:0]  FastLimit = 10'd409;
    localparam logic [9:0]  SlowLimit = 10'd819;
    localparam logic [10:0] SpeedSlow = 11'd750;
    localparam logic [10:0] SpeedMid  = 11'd1000;
    localparam logic [10:0] SpeedFast = 11'd1250;
    // ceil(2^31 / 250); exact floor division for numerators below 2^23.
    localparam logic [23:0] Recip250Q31 = 24'd8589935;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture inputs, set up CORDIC vectors
        logic rotate;    // one CORDIC micro-rotation
        logic scale;     // multiply u by 1/K
        logic err;       // form saturated prediction
        logic pd_mul;    // form PD products
        logic pd_sum;    // sum and form the numerator of the divide by 250
        logic div_step;  // divide by 250 through the reciprocal multiply
        logic finish;    // clamp, pick speed, load output register
    } t_cmd;

    typedef struct packed {
        logic rot_done;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

[design/wfpd_dp.sv]
// Datapath: CORDIC vector/rotation unit, PD arithmetic and divide by 250.
// Depends on wfpd_pkg; sequenced by wfpd_ctrl.
`default_nettype none
module wfpd_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire wfpd_pkg::t_cmd      i_cmd,
    output wfpd_pkg::t_status        o_status,
    input  wire logic [15:0]         i_range_diag_mm,
    input  wire logic [15:0]         i_range_side_mm,
    input  wire logic [15:0]         i_target,
    input  wire logic [15:0]         i_kp,
    input  wire logic [15:0]         i_kd,
    input  wire logic [15:0]         i_look,
    input  wire logic [14:0]         i_max_rate,
    output logic signed [15:0]       o_turn_rate,
    output logic [10:0]              o_forward_speed_mm_s,
    output logic signed [17:0]       o_predicted_wall_mm
);
    localparam int StepW = $clog2(CORDIC_STEPS + 1);
    localparam int VW = 40;  // CORDIC vector width, growth of about 1.65x fits

    logic signed [VW-1:0] r_x, r_y, r_u, r_v;
    logic [StepW-1:0]     r_step;
    logic                 r_bypass;
    logic [15:0]          r_b;
    logic signed [57:0]   r_scaled;
    logic signed [17:0]   r_pred, r_last_err;
    logic signed [35:0]   r_pterm, r_dterm;
    logic                 r_neg;
    logic [37:0]          r_num;
    logic [15:0]          r_quot;
    logic                 r_div_busy;

    logic signed [VW-1:0] sx, sy, su, sv;
    logic signed [VW-1:0] load_x;
    logic signed [57:0]   n_scaled;
    logic signed [19:0]   err_full;
    logic signed [17:0]   n_err;
    logic signed [18:0]   derr;
    logic signed [37:0]   sum;
    logic [37:0]          mag;
    logic [46:0]          prod;
    logic [14:0]          q_clip;
    logic signed [15:0]   rate;

    always_comb begin
        sx = r_x >>> r_step;
        sy = r_y >>> r_step;
        su = r_u >>> r_step;
        sv = r_v >>> r_step;
        load_x = VW'({16'd0, i_range_diag_mm} * {16'd0, wfpd_pkg::Sin45Q16});
        n_scaled = 58'(r_u) * $signed({1'b0, wfpd_pkg::KinvQ16}) + (58'sd1 <<< 31);
        err_full = $signed({4'd0, i_target}) - 20'(r_pred);
        if (err_full > 20'sd131071) n_err = 18'sd131071;
        else if (err_full < -20'sd131072) n_err = -18'sd131072;
        else n_err = err_full[17:0];
        derr = 19'(n_err) - 19'(r_last_err);
        sum = 38'(r_pterm) + 38'(r_dterm);
        mag = sum[37] ? 38'(-sum) : sum;
        // Numerators of 2^23 and above give quotients beyond any clamp limit.
        prod = {24'd0, r_num[22:0]} * {23'd0, wfpd_pkg::Recip250Q31};
        q_clip = (r_quot > {1'b0, i_max_rate}) ? i_max_rate : r_quot[14:0];
        rate = r_neg ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
    end

    assign o_status.rot_done = r_bypass || (r_step == StepW'(CORDIC_STEPS));
    assign o_status.div_done = !r_div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_div_busy <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_x <= load_x;
                r_y <= load_x - VW'($signed({1'b0, i_range_side_mm, 16'd0}));
                r_u <= VW'($signed({1'b0, i_range_side_mm, 16'd0}));
                r_v <= VW'($signed({1'b0, i_look, 16'd0}));
                r_b <= i_range_side_mm;
                r_bypass <= (i_range_diag_mm == 16'd0) && (i_range_side_mm == 16'd0);
                r_step <= '0;
            end
            if (i_cmd.rotate) begin
                if (!r_y[VW-1]) begin
                    r_x <= r_x + sy; r_y <= r_y - sx;
                    r_u <= r_u + sv; r_v <= r_v - su;
                end else begin
                    r_x <= r_x - sy; r_y <= r_y + sx;
                    r_u <= r_u - sv; r_v <= r_v + su;
                end
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.scale) r_scaled <= n_scaled;
            if (i_cmd.err) begin
                if (r_bypass) r_pred <= $signed({2'b00, r_b});
                else if ($signed(r_scaled[57:32]) > 26'sd131071) r_pred <= 18'sd131071;
                else if ($signed(r_scaled[57:32]) < -26'sd131072) r_pred <= -18'sd131072;
                else r_pred <= r_scaled[49:32];
            end
            if (i_cmd.pd_mul) begin
                r_last_err <= n_err;
                r_pterm <= 36'($signed({1'b0, i_kp}) * 36'(n_err));
                r_dterm <= 36'(($signed({1'b0, i_kd}) * 36'(derr)));
            end
            if (i_cmd.pd_sum) begin
                r_neg  <= (sum > 0);
                r_num  <= {mag[35:0], 2'b00} + 38'd125;
                r_div_busy <= 1'b1;
            end
            if (i_cmd.div_step) begin
                r_quot <= (r_num[37:23] != 15'd0) ? 16'hFFFF : prod[46:31];
                r_div_busy <= 1'b0;
            end
            if (i_cmd.finish) begin
                o_turn_rate <= rate;
                o_predicted_wall_mm <= r_pred;
                if (q_clip > 15'(wfpd_pkg::SlowLimit))
                    o_forward_speed_mm_s <= wfpd_pkg::SpeedSlow;
                else if (q_clip > 15'(wfpd_pkg::FastLimit))
                    o_forward_speed_mm_s <= wfpd_pkg::SpeedMid;
                else
                    o_forward_speed_mm_s <= wfpd_pkg::SpeedFast;
            end
        end
    end
endmodule
`default_nettype wire

[design/wfpd_ctrl.sv]
// Controller: sequences the datapath and runs the valid/stall handshakes.
// Depends on wfpd_pkg.
`default_nettype none
module wfpd_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output wfpd_pkg::t_cmd           o_cmd,
    input  wire wfpd_pkg::t_status   i_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_ROT, S_SCALE, S_ERR, S_MUL, S_SUM, S_DIV, S_FIN, S_OUT
    } t_state;
    t_state r_state;
    logic   r_ovalid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.rotate   = (r_state == S_ROT) && !i_status.rot_done;
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.err      = (r_state == S_ERR);
        o_cmd.pd_mul   = (r_state == S_MUL);
        o_cmd.pd_sum   = (r_state == S_SUM);
        o_cmd.div_step = (r_state == S_DIV) && !i_status.div_done;
        o_cmd.finish   = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_ROT;
                S_ROT:   if (i_status.rot_done) r_state <= S_SCALE;
                S_SCALE: r_state <= S_ERR;
                S_ERR:   r_state <= S_MUL;
                S_MUL:   r_state <= S_SUM;
                S_SUM:   r_state <= S_DIV;
                S_DIV:   if (i_status.div_done) r_state <= S_OUT;
                // Wait for the previous result to leave before overwriting it.
                S_OUT:   if (!r_ovalid || !i_stall) r_state <= S_FIN;
                S_FIN: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_ovalid || !i_stall)) else $error("output overwritten");
    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_ovalid) else $error("result not shown");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("commands overlap");
`endif
endmodule
`default_nettype wire

[design/wall_following_pd_steering.sv]
// Wall-following PD steering top level: config registers, controller, datapath.
// The CORDIC loop is skipped when both ranges are zero. One item is in flight at a
// time, and a stalled result holds back the next one.
// Reset (synchronous, active low) restores register defaults and clears the
// stored error and the output valid.
`default_nettype none
module wall_following_pd_steering #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [15:0]        i_range_diag_mm,
    input  wire logic [15:0]        i_range_side_mm,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_turn_rate,
    output logic [10:0]             o_forward_speed_mm_s,
    output logic signed [17:0]      o_predicted_wall_mm,
    input  wire logic               i_cfg_we,
    input  wire logic [wfpd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data
);
    logic [15:0] r_target, r_kp, r_kd, r_look;
    logic [14:0] r_max_rate;
    wfpd_pkg::t_cmd    cmd;
    wfpd_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 16'd800; r_kp <= 16'd256; r_kd <= 16'd26;
            r_look <= 16'd1000; r_max_rate <= 15'd2458;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wfpd_pkg::RegTarget:  r_target <= i_cfg_data;
                wfpd_pkg::RegKp:      r_kp <= i_cfg_data;
                wfpd_pkg::RegKd:      r_kd <= i_cfg_data;
                wfpd_pkg::RegLook:    r_look <= i_cfg_data;
                wfpd_pkg::RegMaxRate: r_max_rate <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    wfpd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .o_cmd(cmd), .i_status(status)
    );

    wfpd_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_range_diag_mm, .i_range_side_mm,
        .i_target(r_target), .i_kp(r_kp), .i_kd(r_kd), .i_look(r_look),
        .i_max_rate(r_max_rate),
        .o_turn_rate, .o_forward_speed_mm_s, .o_predicted_wall_mm
    );
endmodule
`default_nettype wire
